[design/ckhs_pkg.sv]
// Shared types and constants for the canonical k-mer hash sampler.
package ckhs_pkg;

	// Largest supported k-mer length and the matching register width.
	localparam int unsigned MAX_K_DEFAULT = 31;
	localparam int unsigned KMER_W        = 62;
	localparam int unsigned HASH_W        = 64;
	localparam int unsigned CFG_W         = 5;

	// Reset values of the configuration registers.
	localparam logic [CFG_W-1:0] KMER_LENGTH_RST = 5'd31;
	localparam logic [CFG_W-1:0] SAMPLE_BITS_RST = 5'd0;

	// Register index, taken from the word address.
	typedef enum logic {
		REG_KMER_LENGTH = 1'b0,
		REG_SAMPLE_BITS = 1'b1
	} ckhs_reg_t;

	// One sequence item.
	typedef struct packed {
		logic [7:0] seq_byte;
		logic       record_start;
	} ckhs_in_t;

	// One hash result.
	typedef struct packed {
		logic [HASH_W-1:0] hash_key;
		logic              window_full;
		logic              selected;
	} ckhs_out_t;

	// Work handed from the front end to the hash engine.
	typedef struct packed {
		logic              is_base;
		logic              full;
		logic [KMER_W-1:0] fwd;
		logic [KMER_W-1:0] rev;
	} ckhs_entry_t;

endpackage

[design/ckhs_front.sv]
// Front end: decodes bases and keeps the forward and reverse-complement windows.
module ckhs_front #(
	parameter int unsigned MAX_K = ckhs_pkg::MAX_K_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ckhs_pkg::CFG_W-1:0] kmer_length,
	input  logic                       clear_window,
	input  logic                       seq_valid,
	output logic                       seq_stall,
	input  ckhs_pkg::ckhs_in_t         seq_item,
	input  logic                       q_full,
	output logic                       q_push,
	output ckhs_pkg::ckhs_entry_t      q_data
);
	import ckhs_pkg::*;

	localparam int unsigned KW = 2 * MAX_K;

	// Character codes of the four bases in both cases.
	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_T_UP = 8'h54;
	localparam logic [7:0] CHAR_T_LO = 8'h74;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	logic [KW-1:0]    fwd_q, rev_q;
	logic [CFG_W-1:0] fill_q;

	logic             base_ok;
	logic [1:0]       code;
	logic [CFG_W-1:0] eff_k;
	logic [CFG_W-1:0] fill_next;
	logic [5:0]       two_k;
	logic [5:0]       top_shift;
	logic [KW:0]      mask_ext;
	logic [KW-1:0]    mask;
	logic [KW-1:0]    fwd_next, rev_next;
	logic             is_base;
	logic             accept;

	// Base decoding.
	always_comb begin
		base_ok = 1'b1;
		code    = CODE_A;
		case (seq_item.seq_byte) inside
			CHAR_A_UP, CHAR_A_LO: code = CODE_A;
			CHAR_C_UP, CHAR_C_LO: code = CODE_C;
			CHAR_G_UP, CHAR_G_LO: code = CODE_G;
			CHAR_T_UP, CHAR_T_LO: code = CODE_T;
			default:              base_ok = 1'b0;
		endcase
	end

	// Effective window length, clamped to 1..MAX_K.
	always_comb begin
		eff_k = kmer_length;
		if (kmer_length == '0) begin
			eff_k = CFG_W'(1);
		end else if (kmer_length > CFG_W'(MAX_K)) begin
			eff_k = CFG_W'(MAX_K);
		end
	end

	// Window update for a base: shift both registers and trim to 2k bits.
	assign two_k     = {eff_k, 1'b0};
	assign top_shift = {eff_k - CFG_W'(1), 1'b0};
	assign mask_ext  = ((KW+1)'(1) << two_k) - (KW+1)'(1);
	assign mask      = mask_ext[KW-1:0];
	assign fwd_next  = ((fwd_q << 2) | KW'(code)) & mask;
	assign rev_next  = ((rev_q >> 2) | (KW'(~code) << top_shift)) & mask;
	assign fill_next = (fill_q < eff_k) ? fill_q + CFG_W'(1) : eff_k;

	assign is_base   = !seq_item.record_start && base_ok;
	assign seq_stall = q_full;
	assign accept    = seq_valid && !q_full;
	assign q_push    = accept;

	// Entry for the hash engine; only meaningful for a base.
	always_comb begin
		q_data.is_base = is_base;
		q_data.full    = is_base && (fill_next >= eff_k);
		q_data.fwd     = KMER_W'(fwd_next);
		q_data.rev     = KMER_W'(rev_next);
	end

	// Window state: cleared by a record start, a non-base or a length change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= '0;
		end else if (clear_window) begin
			fwd_q  <= '0;
			rev_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (is_base) begin
				fwd_q  <= fwd_next;
				rev_q  <= rev_next;
				fill_q <= fill_next;
			end else begin
				fwd_q  <= '0;
				rev_q  <= '0;
				fill_q <= '0;
			end
		end
	end

endmodule

[design/ckhs_queue.sv]
// Two-entry queue between the front end and the hash engine.
module ckhs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ckhs_pkg::ckhs_entry_t push_data,
	output logic                  full,
	input  logic                  pop,
	output logic                  valid,
	output ckhs_pkg::ckhs_entry_t pop_data
);
	import ckhs_pkg::*;

	ckhs_entry_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// The queue is never pushed when full nor popped when empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !valid))
		else $error("queue overflow or underflow");

endmodule

[design/ckhs_back.sv]
// Hash engine: canonical k-mer selection and a multi-cycle splitmix64 finalizer.
module ckhs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ckhs_pkg::CFG_W-1:0] sample_bits,
	input  logic                       q_valid,
	input  ckhs_pkg::ckhs_entry_t      q_data,
	output logic                       q_pop,
	output logic                       hash_valid,
	input  logic                       hash_stall,
	output ckhs_pkg::ckhs_out_t        hash_item
);
	import ckhs_pkg::*;

	localparam logic [HASH_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [HASH_W-1:0] MIX1   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [HASH_W-1:0] MIX2   = 64'h94d0_49bb_1331_11eb;
	localparam logic [HASH_W-1:0] SALT   = 64'd577;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_MIN  = 11'b000_0000_0010,
		S_ADD  = 11'b000_0000_0100,
		S_M1A  = 11'b000_0000_1000,
		S_M1B  = 11'b000_0001_0000,
		S_M1C  = 11'b000_0010_0000,
		S_X2   = 11'b000_0100_0000,
		S_M2A  = 11'b000_1000_0000,
		S_M2B  = 11'b001_0000_0000,
		S_M2C  = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} ckhs_state_t;

	ckhs_state_t       state_q, state_d;
	logic [KMER_W-1:0] fwd_q, rev_q;
	logic              base_q, full_q;
	logic [HASH_W-1:0] v_q, x_q, acc_q;
	logic              out_valid_q;
	ckhs_out_t         out_q;

	logic [KMER_W-1:0] canon;
	logic [HASH_W-1:0] v_add;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       mul_p;
	logic [HASH_W-1:0] fin_hash;
	logic [31:0]       sample_mask;
	logic              out_free;
	logic              out_load;
	ckhs_out_t         result;

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_free = !out_valid_q || !hash_stall;
	assign out_load = (state_q == S_FIN) && out_free;

	// Canonical k-mer and the first finalizer step.
	assign canon = (fwd_q < rev_q) ? fwd_q : rev_q;
	assign v_add = v_q + GOLDEN;

	// Shared 32x32 multiplier; each 64-bit product takes three partial steps.
	always_comb begin
		mul_a = x_q[31:0];
		mul_b = 32'd0;
		unique case (state_q)
			S_M1A: begin
				mul_a = x_q[31:0];
				mul_b = MIX1[31:0];
			end
			S_M1B: begin
				mul_a = x_q[31:0];
				mul_b = MIX1[63:32];
			end
			S_M1C: begin
				mul_a = x_q[63:32];
				mul_b = MIX1[31:0];
			end
			S_M2A: begin
				mul_a = x_q[31:0];
				mul_b = MIX2[31:0];
			end
			S_M2B: begin
				mul_a = x_q[31:0];
				mul_b = MIX2[63:32];
			end
			S_M2C: begin
				mul_a = x_q[63:32];
				mul_b = MIX2[31:0];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = 32'd0;
			end
		endcase
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// Final mix and sampling decision.
	assign fin_hash    = acc_q ^ (acc_q >> 31);
	assign sample_mask = (32'd1 << sample_bits) - 32'd1;

	always_comb begin
		result.hash_key    = base_q ? fin_hash : '0;
		result.window_full = base_q && full_q;
		result.selected    = base_q && full_q && ((fin_hash[31:0] & sample_mask) == 32'd0);
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					state_d = q_data.is_base ? S_MIN : S_FIN;
				end
			end
			S_MIN:   state_d = S_ADD;
			S_ADD:   state_d = S_M1A;
			S_M1A:   state_d = S_M1B;
			S_M1B:   state_d = S_M1C;
			S_M1C:   state_d = S_X2;
			S_X2:    state_d = S_M2A;
			S_M2A:   state_d = S_M2B;
			S_M2B:   state_d = S_M2C;
			S_M2C:   state_d = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers of the finalizer.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			fwd_q  <= q_data.fwd;
			rev_q  <= q_data.rev;
			base_q <= q_data.is_base;
			full_q <= q_data.full;
		end
		case (state_q)
			S_MIN:  v_q   <= {{(HASH_W-KMER_W){1'b0}}, canon} ^ SALT;
			S_ADD:  x_q   <= v_add ^ (v_add >> 30);
			S_M1A:  acc_q <= mul_p;
			S_M1B:  acc_q <= {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
			S_M1C:  acc_q <= {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
			S_X2:   x_q   <= acc_q ^ (acc_q >> 27);
			S_M2A:  acc_q <= mul_p;
			S_M2B:  acc_q <= {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
			S_M2C:  acc_q <= {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
			default: begin
			end
		endcase
	end

	// Output register: a finished result waits here while the next item is hashed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign hash_valid = out_valid_q;
	assign hash_item  = out_q;

	// A selected k-mer always comes from a full window.
	a_sel_full: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash_item.selected |-> hash_item.window_full)
		else $error("selected result without a full window");

	// The queue is only popped by an idle engine.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == S_IDLE) && q_valid)
		else $error("queue popped while the engine is busy");

	// A finished result is presented in the following cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> hash_valid)
		else $error("loaded result not presented");

endmodule

[design/canonical_kmer_hash_sampler.sv]
// Top level of the canonical k-mer hash sampler: registers, front end, queue, hash engine.
//
//  channel   direction  handshake               payload
//  seq       in         seq_valid / seq_stall   seq_item  (seq_byte, record_start)
//  hash      out        hash_valid / hash_stall hash_item (hash_key, window_full, selected)
//  config    in         APB psel/penable/pwrite paddr, pwdata, prdata
//
//  In the hash engine a base passes through MIN, ADD, M1A-M1C, X2, M2A-M2C and FIN, the
//  shared 32x32 multiplier forming each 64-bit product in three partial steps; a record
//  start or a non-base byte goes from IDLE straight to FIN. The front end takes an item
//  whenever the two-entry queue has room. Reset clears the window, the queue and the
//  engine; the registers return to length 31 and no sample bits. A stalled result holds
//  in the output register while the engine finishes the next item.
module canonical_kmer_hash_sampler #(
	parameter int unsigned MAX_K = ckhs_pkg::MAX_K_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seq_valid,
	output logic                seq_stall,
	input  ckhs_pkg::ckhs_in_t  seq_item,
	output logic                hash_valid,
	input  logic                hash_stall,
	output ckhs_pkg::ckhs_out_t hash_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ckhs_pkg::*;

	logic [CFG_W-1:0] kmer_length_q, sample_bits_q;
	logic             cfg_wr;
	ckhs_reg_t        reg_sel;
	logic             clear_window;

	logic             q_push, q_full, q_pop, q_valid;
	ckhs_entry_t      q_in, q_out;

	// Configuration port: word address selects the register.
	assign pready       = 1'b1;
	assign reg_sel      = ckhs_reg_t'(paddr[2]);
	assign cfg_wr       = psel && penable && pwrite;
	assign clear_window = cfg_wr && (reg_sel == REG_KMER_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KMER_LENGTH_RST;
			sample_bits_q <= SAMPLE_BITS_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_KMER_LENGTH: kmer_length_q <= pwdata[CFG_W-1:0];
				REG_SAMPLE_BITS: sample_bits_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_sel)
			REG_KMER_LENGTH: prdata = {{(32-CFG_W){1'b0}}, kmer_length_q};
			REG_SAMPLE_BITS: prdata = {{(32-CFG_W){1'b0}}, sample_bits_q};
			default:         prdata = 32'd0;
		endcase
	end

	ckhs_front #(
		.MAX_K(MAX_K)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.kmer_length (kmer_length_q),
		.clear_window(clear_window),
		.seq_valid   (seq_valid),
		.seq_stall   (seq_stall),
		.seq_item    (seq_item),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	ckhs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_data (q_out)
	);

	ckhs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_bits(sample_bits_q),
		.q_valid    (q_valid),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash_item  (hash_item)
	);

endmodule
